// ===== rtl/dstcr_pkg.sv =====
package dstcr_pkg;

    localparam int CELL_COLS   = 12;
    localparam int GLYPH_COLS  = 5;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [GLYPH_COLS-1:0][7:0] t_glyph;

    // one character's worth of work for the write sequencer
    typedef struct packed {
        t_glyph     glyph;
        logic [7:0] column;
        logic [2:0] page;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qport;

    // 5x7 font, column 0 in the lowest byte, unknown codes blank
    function automatic t_glyph font_glyph(input logic [7:0] code);
        t_glyph g;
        unique case (code)
            8'h21:   g = t_glyph'(40'h00_00_5F_00_00);
            8'h41:   g = t_glyph'(40'h7E_11_11_11_7E);
            8'h42:   g = t_glyph'(40'h36_49_49_49_7F);
            8'h44:   g = t_glyph'(40'h3E_41_41_41_7F);
            8'h47:   g = t_glyph'(40'h7A_49_49_41_3E);
            8'h49:   g = t_glyph'(40'h00_41_7F_41_00);
            8'h52:   g = t_glyph'(40'h46_29_19_09_7F);
            8'h53:   g = t_glyph'(40'h31_49_49_49_46);
            8'h61:   g = t_glyph'(40'h78_54_54_54_20);
            8'h63:   g = t_glyph'(40'h20_44_44_44_38);
            8'h64:   g = t_glyph'(40'h7F_48_44_44_38);
            8'h65:   g = t_glyph'(40'h18_54_54_54_38);
            8'h68:   g = t_glyph'(40'h78_04_04_08_7F);
            8'h69:   g = t_glyph'(40'h00_40_7D_44_00);
            8'h6B:   g = t_glyph'(40'h00_44_28_10_7F);
            8'h6E:   g = t_glyph'(40'h78_04_04_08_7C);
            8'h6F:   g = t_glyph'(40'h38_44_44_44_38);
            8'h70:   g = t_glyph'(40'h08_14_14_14_7C);
            8'h71:   g = t_glyph'(40'h7C_18_14_14_08);
            8'h72:   g = t_glyph'(40'h08_04_04_08_7C);
            8'h73:   g = t_glyph'(40'h24_54_54_54_48);
            8'h74:   g = t_glyph'(40'h20_40_44_3F_04);
            8'h75:   g = t_glyph'(40'h7C_20_40_40_3C);
            8'h77:   g = t_glyph'(40'h3C_40_38_40_3C);
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/double_size_text_column_renderer_unit.sv =====
// double-size text renderer: one character in, up to 24 framebuffer byte writes out
// input stream (s side): one transfer per character; tuser carries the string
//   start and centering flags, tdata the code, start column/page and string length
// output stream (m side): one transfer per byte write; tdata holds the address
//   (page * PANEL_WIDTH + column) and the pixel byte, tlast marks the last write
//   of a character
// a front stage keeps the cursor, looks up the glyph and posts a command into a
//   two-entry queue; a back sequencer walks 12 columns x 2 pages, one write a cycle
//   while the receiver is ready; its single write port sets the pace at 24 writes
//   per character (12 when the bottom page lies past the panel); characters that
//   emit nothing are taken by the front stage and never reach the queue
// from idle, the first write passes the queue, the sequencer and then the output register
// s_tready drops only while the queue holds two pending characters
// a stalled receiver holds the output register; the sequencer and then the queue
//   back up behind it, nothing is dropped
// reset clears the cursor to column 0, page 0, the line-full flag, the queue and
//   the output valid
module double_size_text_column_renderer_unit #(
    parameter int PANEL_WIDTH = 128,
    parameter int PANEL_PAGES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // char_code[7:0], start_column[14:8],
                                     // start_page[17:15], string_length[25:18], zero pad
    input  logic [1:0]  i_s_tuser,   // first_of_string[0], center_mode[1]
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // write_address[9:0], write_data[17:10], zero pad
    output logic        o_m_tlast    // last_of_char
);
    import dstcr_pkg::*;

    logic       s_accept;
    logic       q_full;
    logic       q_pop;
    t_qport     q_push;
    t_qport     q_head;
    logic [9:0] wr_addr;
    logic [7:0] wr_data;

    // an input transfer completes whenever the queue has room
    assign o_s_tready = !q_full;
    assign s_accept   = i_s_tvalid && o_s_tready;

    dstcr_front #(
        .PANEL_WIDTH(PANEL_WIDTH),
        .PANEL_PAGES(PANEL_PAGES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (s_accept),
        .i_char_code      (i_s_tdata[7:0]),
        .i_first_of_string(i_s_tuser[0]),
        .i_center_mode    (i_s_tuser[1]),
        .i_start_column   (i_s_tdata[14:8]),
        .i_start_page     (i_s_tdata[17:15]),
        .i_string_length  (i_s_tdata[25:18]),
        .o_push           (q_push)
    );

    dstcr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_pop  (q_pop),
        .o_head (q_head),
        .o_full (q_full)
    );

    dstcr_back #(
        .PANEL_WIDTH(PANEL_WIDTH),
        .PANEL_PAGES(PANEL_PAGES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .o_pop          (q_pop),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_write_address(wr_addr),
        .o_write_data   (wr_data),
        .o_last_of_char (o_m_tlast)
    );

    assign o_m_tdata = {6'b000000, wr_data, wr_addr};

    // a command is never posted into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push.valid |-> !q_full)
        else $error("command posted into full queue");

    // the sequencer only takes a command that is present
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_head.valid)
        else $error("command taken from empty queue");

    // a posted command reaches an empty queue, so the queue is not empty next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push.valid && !q_head.valid) |=> q_head.valid || $past(q_pop) || q_pop)
        else $error("posted command lost");

    // output valid is low right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

// ===== rtl/dstcr_front.sv =====
module dstcr_front #(
    parameter int PANEL_WIDTH = 128,
    parameter int PANEL_PAGES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_char_code,
    input  logic             i_first_of_string,
    input  logic             i_center_mode,
    input  logic [6:0]       i_start_column,
    input  logic [2:0]       i_start_page,
    input  logic [7:0]       i_string_length,
    output dstcr_pkg::t_qport o_push
);
    import dstcr_pkg::*;

    localparam logic [8:0]  LIMIT   = 9'(PANEL_WIDTH - CELL_COLS);
    localparam logic [11:0] WIDTH12 = 12'(PANEL_WIDTH);
    localparam logic [3:0]  PAGES4  = 4'(PANEL_PAGES);

    logic [7:0]  r_col, n_col;
    logic [2:0]  r_page, n_page;
    logic        r_full, n_full;
    logic [11:0] str_w;
    logic [11:0] spare;
    logic [7:0]  centered;
    logic [7:0]  col_eff;
    logic        full_eff;
    logic        too_far;

    always_comb begin
        str_w    = {1'b0, i_string_length, 3'b000} + {2'b00, i_string_length, 2'b00};
        spare    = WIDTH12 - str_w;
        centered = (str_w < WIDTH12) ? spare[8:1] : 8'd0;
        if (i_first_of_string) begin
            col_eff  = i_center_mode ? centered : {1'b0, i_start_column};
            n_page   = i_start_page;
            full_eff = 1'b0;
        end else begin
            col_eff  = r_col;
            n_page   = r_page;
            full_eff = r_full;
        end
        too_far = full_eff || ({1'b0, col_eff} > LIMIT);
        n_full  = too_far;
        n_col   = too_far ? col_eff : col_eff + 8'(CELL_COLS);

        o_push.valid      = i_accept && !too_far && ({1'b0, n_page} < PAGES4);
        o_push.cmd.glyph  = font_glyph(i_char_code);
        o_push.cmd.column = col_eff;
        o_push.cmd.page   = n_page;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_page <= '0;
            r_full <= 1'b0;
        end else if (i_accept) begin
            r_col  <= n_col;
            r_page <= n_page;
            r_full <= n_full;
        end
    end

endmodule

// ===== rtl/dstcr_queue.sv =====
module dstcr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dstcr_pkg::t_qport i_push,
    input  logic              i_pop,
    output dstcr_pkg::t_qport o_head,
    output logic              o_full
);
    import dstcr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full       = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/dstcr_back.sv =====
module dstcr_back #(
    parameter int PANEL_WIDTH = 128,
    parameter int PANEL_PAGES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dstcr_pkg::t_qport i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [9:0]        o_write_address,
    output logic [7:0]        o_write_data,
    output logic              o_last_of_char
);
    import dstcr_pkg::*;

    localparam logic [3:0]  PAGES4   = 4'(PANEL_PAGES);
    localparam logic [11:0] WIDTH12  = 12'(PANEL_WIDTH);
    localparam logic [3:0]  LAST_COL = 4'(CELL_COLS - 1);
    localparam logic [3:0]  INK_COLS = 4'(2 * GLYPH_COLS);

    function automatic logic [7:0] stretch(input logic [3:0] nib);
        logic [7:0] r;
        for (int k = 0; k < 4; k++) begin
            r[2*k]   = nib[k];
            r[2*k+1] = nib[k];
        end
        return r;
    endfunction

    logic        r_busy;
    t_cmd        r_cmd;
    logic [3:0]  r_col;
    logic        r_pg;
    logic        r_ovalid;
    logic [9:0]  r_addr;
    logic [7:0]  r_data;
    logic        r_last;

    logic        beat;
    logic        has_bottom;
    logic        last_pg;
    logic        last_beat;
    logic        load;
    logic [7:0]  g;
    logic [3:0]  page;
    logic [11:0] addr_sum;

    always_comb begin
        beat       = r_busy && (!r_ovalid || i_ready);
        has_bottom = ({1'b0, r_cmd.page} + 4'd1) < PAGES4;
        last_pg    = r_pg || !has_bottom;
        last_beat  = last_pg && (r_col == LAST_COL);
        load       = i_head.valid && (!r_busy || (beat && last_beat));
        g          = (r_col < INK_COLS) ? r_cmd.glyph[r_col[3:1]] : 8'h00;
        page       = {1'b0, r_cmd.page} + {3'b000, r_pg};
        addr_sum   = 12'(page) * WIDTH12 + {4'b0000, r_cmd.column} + {8'h00, r_col};
    end

    assign o_pop           = load;
    assign o_valid         = r_ovalid;
    assign o_write_address = r_addr;
    assign o_write_data    = r_data;
    assign o_last_of_char  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (beat && last_beat) begin
                r_busy <= 1'b0;
            end
            if (beat) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_head.cmd;
            r_col <= '0;
            r_pg  <= 1'b0;
        end else if (beat) begin
            if (last_pg) begin
                r_pg  <= 1'b0;
                r_col <= r_col + 4'd1;
            end else begin
                r_pg  <= 1'b1;
            end
        end
        if (beat) begin
            r_addr <= addr_sum[9:0];
            r_data <= r_pg ? stretch(g[7:4]) : stretch(g[3:0]);
            r_last <= last_beat;
        end
    end

endmodule

// ===== dv/dstcr_write_checker.sv =====
`timescale 1ns / 1ps

module dstcr_write_checker #(
    parameter int PANEL_WIDTH = 128,
    parameter int PANEL_PAGES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // char_code[7:0], start_column[14:8],
                                     // start_page[17:15], string_length[25:18], zero pad
    input  logic [1:0]  i_s_tuser,   // first_of_string[0], center_mode[1]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // write_address[9:0], write_data[17:10], zero pad
    input  logic        i_m_tlast,   // last_of_char
    output int          o_fail_count,
    output int          o_pending
);
    import dstcr_pkg::*;

    typedef struct packed {
        logic [9:0] addr;
        logic [7:0] pixels;
        logic       last;
    } t_fb_write;

    t_fb_write  expected_writes[$];
    logic [7:0] cursor_col;
    logic [2:0] cursor_page;
    logic       line_full;

    // glyph columns left to right, column 0 in the top byte
    function automatic logic [39:0] glyph_bitmap(input logic [7:0] code);
        case (code)
            8'h21:   return 40'h00_00_5F_00_00;
            8'h41:   return 40'h7E_11_11_11_7E;
            8'h42:   return 40'h7F_49_49_49_36;
            8'h44:   return 40'h7F_41_41_41_3E;
            8'h47:   return 40'h3E_41_49_49_7A;
            8'h49:   return 40'h00_41_7F_41_00;
            8'h52:   return 40'h7F_09_19_29_46;
            8'h53:   return 40'h46_49_49_49_31;
            8'h61:   return 40'h20_54_54_54_78;
            8'h63:   return 40'h38_44_44_44_20;
            8'h64:   return 40'h38_44_44_48_7F;
            8'h65:   return 40'h38_54_54_54_18;
            8'h68:   return 40'h7F_08_04_04_78;
            8'h69:   return 40'h00_44_7D_40_00;
            8'h6B:   return 40'h7F_10_28_44_00;
            8'h6E:   return 40'h7C_08_04_04_78;
            8'h6F:   return 40'h38_44_44_44_38;
            8'h70:   return 40'h7C_14_14_14_08;
            8'h71:   return 40'h08_14_14_18_7C;
            8'h72:   return 40'h7C_08_04_04_08;
            8'h73:   return 40'h48_54_54_54_24;
            8'h74:   return 40'h04_3F_44_40_20;
            8'h75:   return 40'h3C_40_40_20_7C;
            8'h77:   return 40'h3C_40_38_40_3C;
            default: return 40'h0;   // space and unknown codes
        endcase
    endfunction

    // each nibble bit becomes two pixels
    function automatic logic [7:0] double_nibble(input logic [3:0] nib);
        logic [7:0] r;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            r[2*k +: 2] = {2{nib[k]}};
        end
        return r;
    endfunction

    // updates the cursor and queues the writes one character causes
    function automatic void render_char(
        input logic [7:0] code,
        input logic       first,
        input logic       center,
        input logic [6:0] scol,
        input logic [2:0] spage,
        input logic [7:0] slen
    );
        t_fb_write   burst[2*CELL_COLS];
        int          n_writes;
        int          text_width;
        int          page;
        logic [31:0] addr;
        logic [39:0] bitmap;
        logic [7:0]  column_bits;
        logic [7:0]  stripe[2];

        if (first) begin
            if (center) begin
                text_width = int'(slen) * CELL_COLS;
                cursor_col = (text_width < PANEL_WIDTH) ?
                             8'((PANEL_WIDTH - text_width) / 2) : 8'd0;
            end else begin
                cursor_col = {1'b0, scol};
            end
            cursor_page = spage;
            line_full   = 1'b0;
        end

        if (line_full || int'(cursor_col) > PANEL_WIDTH - CELL_COLS) begin
            line_full = 1'b1;
            return;
        end

        n_writes = 0;
        bitmap   = glyph_bitmap(code);
        for (int col = 0; col < CELL_COLS; col++) begin
            column_bits = (col < 2*GLYPH_COLS) ? bitmap[39 - 8*(col/2) -: 8] : 8'h00;
            stripe[0]   = double_nibble(column_bits[3:0]);
            stripe[1]   = double_nibble(column_bits[7:4]);
            for (int pg = 0; pg < 2; pg++) begin
                page = int'(cursor_page) + pg;
                if (page < PANEL_PAGES) begin
                    addr = page * PANEL_WIDTH + int'(cursor_col) + col;
                    burst[n_writes] = '{addr[9:0], stripe[pg], 1'b0};
                    n_writes++;
                end
            end
        end
        cursor_col = cursor_col + 8'(CELL_COLS);

        for (int i = 0; i < n_writes; i++) begin
            burst[i].last = (i == n_writes - 1);
            expected_writes.push_back(burst[i]);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_fb_write want;
        if (!i_rst_n) begin
            expected_writes.delete();
            cursor_col  = '0;
            cursor_page = '0;
            line_full   = 1'b0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                render_char(i_s_tdata[7:0], i_s_tuser[0], i_s_tuser[1],
                            i_s_tdata[14:8], i_s_tdata[17:15], i_s_tdata[25:18]);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_writes.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    $display("%0t: unexpected write: expected none,", $time,
                             " actual addr=%0d data=%02h last=%0b",
                             i_m_tdata[9:0], i_m_tdata[17:10], i_m_tlast);
                end else begin
                    want = expected_writes.pop_front();
                    if (i_m_tdata[9:0] !== want.addr || i_m_tdata[17:10] !== want.pixels ||
                        i_m_tlast !== want.last || i_m_tdata[23:18] !== '0) begin
                        o_fail_count = o_fail_count + 1;
                        $display("%0t: write mismatch: expected addr=%0d data=%02h last=%0b pad=0,",
                                 $time, want.addr, want.pixels, want.last,
                                 " actual addr=%0d data=%02h last=%0b pad=%0h",
                                 i_m_tdata[9:0], i_m_tdata[17:10], i_m_tlast,
                                 i_m_tdata[23:18]);
                    end
                end
            end
        end
        o_pending <= expected_writes.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int PANEL_WIDTH = 128;
    localparam int PANEL_PAGES = 8;
    // random items on top of the directed ones
    localparam int RANDOM_ITEMS = 308;
    // random idling stops once this many random items have gone in
    localparam int CALM_AFTER = 260;

    // every code the font knows plus space, used to bias the random characters
    localparam logic [7:0] FONT_CODES[25] = '{
        8'h20, 8'h21, 8'h41, 8'h42, 8'h44, 8'h47, 8'h49, 8'h52, 8'h53,
        8'h61, 8'h63, 8'h64, 8'h65, 8'h68, 8'h69, 8'h6B, 8'h6E, 8'h6F,
        8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h77
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // char_code, start_column, start_page, string_length, zero pad
    logic [1:0]  s_tuser;    // first_of_string, center_mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;    // write_address, write_data, zero pad
    logic        m_tlast;

    int          fail_count;
    int          pending_writes;
    bit          idle_on = 1'b1;
    int          stall_left = 0;

    always #5 i_clk = ~i_clk;

    double_size_text_column_renderer_unit #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PANEL_PAGES (PANEL_PAGES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    dstcr_write_checker #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PANEL_PAGES (PANEL_PAGES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_writes)
    );

    // receiver back-pressure: random stalls, none in the calm tail
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // mostly font characters, now and then any byte
    function automatic logic [7:0] pick_code();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom);
        return FONT_CODES[$urandom_range(0, 24)];
    endfunction

    // one character transfer; valid stays up into the next call unless a gap is taken
    task automatic send_char(
        input logic [7:0] code,
        input logic       first,
        input logic       center,
        input logic [6:0] scol,
        input logic [2:0] spage,
        input logic [7:0] slen
    );
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, slen, spage, scol, code};
        s_tuser  <= {center, first};
        do @(posedge i_clk); while (!s_tready);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            // idle gap with junk on the bus, which must be ignored
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 2'($urandom);
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // a well-formed string: first item loads the cursor, the rest only carry codes
    task automatic send_string(input int len);
        logic       center;
        logic [6:0] scol;
        logic [2:0] spage;
        logic [7:0] slen;
        center = 1'($urandom);
        // mostly columns that leave room, sometimes any column
        scol   = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 116));
        spage  = 3'($urandom);
        // the centering length usually matches the string
        slen   = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(len);
        send_char(pick_code(), 1'b1, center, scol, spage, slen);
        for (int k = 1; k < len; k++) begin
            // continuation items: cursor fields are don't-care, so randomize them
            send_char(pick_code(), 1'b0, 1'($urandom), 7'($urandom), 3'($urandom),
                      8'($urandom));
        end
    endtask

    initial begin
        int sent;
        int len;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: character before any string start uses the reset cursor
        send_char(8'h41, 1'b0, 1'b0, 7'd0,   3'd0, 8'd0);
        // plain string at column 0, page 0, with unknown codes and space
        send_char(8'h42, 1'b1, 1'b0, 7'd0,   3'd0, 8'd0);
        send_char(8'h21, 1'b0, 1'b0, 7'd0,   3'd0, 8'd0);
        send_char(8'hFF, 1'b0, 1'b0, 7'd0,   3'd0, 8'd0);
        send_char(8'h00, 1'b0, 1'b0, 7'd0,   3'd0, 8'd0);
        send_char(8'h20, 1'b0, 1'b0, 7'd0,   3'd0, 8'd0);
        // centering: empty string lands mid-panel, start column ignored
        send_char(8'h77, 1'b1, 1'b1, 7'd127, 3'd3, 8'd0);
        // centering: just fits, just too wide, widest length
        send_char(8'h47, 1'b1, 1'b1, 7'd0,   3'd2, 8'd10);
        send_char(8'h53, 1'b1, 1'b1, 7'd0,   3'd2, 8'd11);
        send_char(8'h52, 1'b1, 1'b1, 7'd0,   3'd5, 8'd255);
        send_char(8'h63, 1'b1, 1'b1, 7'd0,   3'd4, 8'd5);
        // out of room: last fitting column, then the line fills and stays full
        send_char(8'h44, 1'b1, 1'b0, 7'd116, 3'd0, 8'd0);
        send_char(8'h6B, 1'b0, 1'b0, 7'd0,   3'd0, 8'd0);
        send_char(8'h61, 1'b0, 1'b0, 7'd0,   3'd0, 8'd0);
        // out of room straight away
        send_char(8'h49, 1'b1, 1'b0, 7'd117, 3'd1, 8'd0);
        send_char(8'h65, 1'b1, 1'b0, 7'd127, 3'd7, 8'd255);
        // bottom page past the panel: only top-page writes
        send_char(8'h74, 1'b1, 1'b0, 7'd40,  3'd7, 8'd0);
        send_char(8'h75, 1'b0, 1'b0, 7'd0,   3'd0, 8'd0);
        send_char(8'h64, 1'b1, 1'b0, 7'd0,   3'd7, 8'd0);
        // lowest full line, run to the right edge and past it
        send_char(8'h68, 1'b1, 1'b0, 7'd104, 3'd6, 8'd0);
        send_char(8'h6F, 1'b0, 1'b0, 7'd0,   3'd0, 8'd0);
        send_char(8'h70, 1'b0, 1'b0, 7'd0,   3'd0, 8'd0);

        // random: mostly well-formed strings, some stray items
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                send_char(8'($urandom), 1'($urandom), 1'($urandom), 7'($urandom),
                          3'($urandom), 8'($urandom));
                sent++;
            end else begin
                len = $urandom_range(1, 12);
                send_string(len);
                sent += len;
            end
            idle_on = (sent < CALM_AFTER);
        end
        idle_on  = 1'b0;
        s_tvalid <= 1'b0;

        // drain: let the checker see the last transfer, then wait out the writes
        @(posedge i_clk);
        while (pending_writes != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("** double_size_text_column_renderer_unit: PASSED **");
        end else begin
            $display("** double_size_text_column_renderer_unit: FAILED **");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("** double_size_text_column_renderer_unit: FAILED **");
        $finish;
    end

endmodule

// ===== double_size_text_column_renderer_unit.f =====
rtl/dstcr_pkg.sv
rtl/dstcr_front.sv
rtl/dstcr_queue.sv
rtl/dstcr_back.sv
rtl/double_size_text_column_renderer_unit.sv
dv/dstcr_write_checker.sv
dv/testbench.sv
